@@ design/range_reservation_admission_core_macros.svh @@
`ifndef RANGE_RESERVATION_ADMISSION_CORE_MACROS_SVH
`define RANGE_RESERVATION_ADMISSION_CORE_MACROS_SVH

// Same-cycle check, sampled on clk and masked while arst_n is low
`define RRA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle check
`define RRA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/rra_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rra_pkg;

	localparam int FUNC_W = 2;
	localparam int AMT_W  = 32;
	localparam int SLOT_W = 10;
	localparam int CNT_W  = 20;

	localparam int NUM_SLOTS_DEF    = 1024;
	localparam int MAX_REQUESTS_DEF = 1048575;
	localparam int CNT_MAX          = (1 << CNT_W) - 1;

	localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_REQUEST = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

	typedef enum logic {
		WALK_IDLE,
		WALK_STEP
	} walk_state_t;

	typedef struct packed {
		logic              load;
		logic              run;
		logic [AMT_W-1:0]  amount;
		logic [SLOT_W-1:0] lo;
		logic [SLOT_W-1:0] hi;
	} walk_cmd_t;

	typedef struct packed {
		logic done;
		logic fail;
	} walk_resp_t;

endpackage

`default_nettype wire

@@ design/rra_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rra_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ design/rra_walk.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rra_walk #(
	parameter int NUM_SLOTS = rra_pkg::NUM_SLOTS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rra_pkg::walk_cmd_t cmd,
	output rra_pkg::walk_resp_t     resp
);

	localparam int AW = $clog2(NUM_SLOTS);

	rra_pkg::walk_state_t state_q, state_d;

	logic [rra_pkg::AMT_W-1:0]  amount_q;
	logic [rra_pkg::SLOT_W-1:0] cur_q;
	logic [rra_pkg::SLOT_W-1:0] hi_q;

	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	logic [rra_pkg::AMT_W-1:0] ram_wdata;
	logic [AW-1:0]             ram_raddr;
	logic [rra_pkg::AMT_W-1:0] ram_rdata;

	// Shared subtractor: the borrow out doubles as the over-capacity compare
	logic [rra_pkg::AMT_W:0] diff;
	logic                    short_fall;
	logic                    at_end;

	assign diff       = {1'b0, ram_rdata} - {1'b0, amount_q};
	assign short_fall = diff[rra_pkg::AMT_W];
	assign at_end     = (cur_q == hi_q);

	rra_ram #(
		.WIDTH(rra_pkg::AMT_W),
		.DEPTH(NUM_SLOTS)
	) u_cap_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			rra_pkg::WALK_IDLE: begin
				if (cmd.run) begin
					state_d = rra_pkg::WALK_STEP;
				end
			end
			rra_pkg::WALK_STEP: begin
				if (short_fall || at_end) begin
					state_d = rra_pkg::WALK_IDLE;
				end
			end
			default: state_d = rra_pkg::WALK_IDLE;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(cur_q);
		ram_wdata = diff[rra_pkg::AMT_W-1:0];
		ram_raddr = AW'(cur_q);
		resp      = '0;
		case (state_q)
			rra_pkg::WALK_IDLE: begin
				if (cmd.load) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(cmd.lo);
					ram_wdata = cmd.amount;
				end
				ram_raddr = AW'(cmd.lo);
			end
			rra_pkg::WALK_STEP: begin
				// write back the reduced slot and fetch the next one in the same cycle
				ram_we    = !short_fall;
				ram_raddr = AW'(cur_q + 1'b1);
				resp.done = short_fall || at_end;
				resp.fail = short_fall;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rra_pkg::WALK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rra_pkg::WALK_IDLE && cmd.run) begin
			amount_q <= cmd.amount;
			cur_q    <= cmd.lo;
			hi_q     <= cmd.hi;
		end else if (state_q == rra_pkg::WALK_STEP && !short_fall && !at_end) begin
			cur_q <= cur_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

@@ design/range_reservation_admission_core.sv @@
// Channel   Handshake           Payload
// command   start / busy        func, amount, first_slot, last_slot
// result    done (one cycle)    failed, first_failing_request, requests_seen
//
// A walking request holds the slot walker after it is taken, checking its slots in order
// (first read issued as it is taken, write-back overlapped with the next read), up
// to NUM_SLOTS slots, fewer if a slot falls short; its result strobes the cycle after.
// Every other command gives its result in the cycle after it is taken.
// busy is high from a taken walk until its result; done cannot be held.
// arst_n clears the counter, failure flag and index; capacities are not reset.
`timescale 1ns / 1ps
`default_nettype none

module range_reservation_admission_core #(
	parameter int NUM_SLOTS    = rra_pkg::NUM_SLOTS_DEF,
	parameter int MAX_REQUESTS = rra_pkg::MAX_REQUESTS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [rra_pkg::FUNC_W-1:0]   func,
	input  wire logic [rra_pkg::AMT_W-1:0]    amount,
	input  wire logic [rra_pkg::SLOT_W-1:0]   first_slot,
	input  wire logic [rra_pkg::SLOT_W-1:0]   last_slot,
	output logic                              done,
	output logic                              failed,
	output logic      [rra_pkg::CNT_W-1:0]    first_failing_request,
	output logic      [rra_pkg::CNT_W-1:0]    requests_seen
);

`include "range_reservation_admission_core_macros.svh"

	localparam int COUNT_CAP = (MAX_REQUESTS < rra_pkg::CNT_MAX) ?
		MAX_REQUESTS : rra_pkg::CNT_MAX;

	logic                      pending_q;
	logic                      done_q;
	logic                      failed_q;
	logic [rra_pkg::CNT_W-1:0] fail_idx_q;
	logic [rra_pkg::CNT_W-1:0] req_cnt_q;

	logic                       accept;
	logic                       first_in_range;
	logic                       below_cap;
	logic                       launch;
	logic [rra_pkg::SLOT_W-1:0] hi_clamped;

	rra_pkg::walk_cmd_t  cmd;
	rra_pkg::walk_resp_t resp;

	assign accept         = start && !busy;
	assign first_in_range = (32'(first_slot) < 32'(NUM_SLOTS));
	assign below_cap      = (req_cnt_q < rra_pkg::CNT_W'(COUNT_CAP));
	assign hi_clamped     = (32'(last_slot) >= 32'(NUM_SLOTS)) ?
		rra_pkg::SLOT_W'(NUM_SLOTS - 1) : last_slot;

	// only a live, non-empty, in-range request starts a walk
	assign launch = accept && (func == rra_pkg::FUNC_REQUEST) && below_cap && !failed_q &&
		(first_slot <= last_slot) && first_in_range;

	assign cmd.load   = accept && (func == rra_pkg::FUNC_LOAD) && first_in_range;
	assign cmd.run    = launch;
	assign cmd.amount = amount;
	assign cmd.lo     = first_slot;
	assign cmd.hi     = hi_clamped;

	rra_walk #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_walk (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.resp  (resp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q  <= 1'b0;
			done_q     <= 1'b0;
			failed_q   <= 1'b0;
			fail_idx_q <= '0;
			req_cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				case (func)
					rra_pkg::FUNC_REQUEST: begin
						if (below_cap) begin
							req_cnt_q <= req_cnt_q + 1'b1;
						end
						if (launch) begin
							pending_q <= 1'b1;
						end else begin
							done_q <= 1'b1;
						end
					end
					rra_pkg::FUNC_RESTART: begin
						req_cnt_q  <= '0;
						failed_q   <= 1'b0;
						fail_idx_q <= '0;
						done_q     <= 1'b1;
					end
					default: begin
						done_q <= 1'b1;
					end
				endcase
			end
			if (resp.done) begin
				pending_q <= 1'b0;
				done_q    <= 1'b1;
				// the counter already holds this request's one-based index
				if (resp.fail) begin
					failed_q   <= 1'b1;
					fail_idx_q <= req_cnt_q;
				end
			end
		end
	end

	assign busy                  = pending_q;
	assign done                  = done_q;
	assign failed                = failed_q;
	assign first_failing_request = fail_idx_q;
	assign requests_seen         = req_cnt_q;

	`RRA_ASSERT_NOW(a_walk_done_pending, resp.done, pending_q,
		"walker finished with no request outstanding")
	`RRA_ASSERT_NEXT(a_short_cmd_result, accept && !launch, done_q,
		"no result the cycle after a non-walking transaction")
	`RRA_ASSERT_NOW(a_fail_has_index, failed_q, fail_idx_q != '0,
		"failure flag set without a failing request index")
	`RRA_ASSERT_NOW(a_count_capped, 1'b1, req_cnt_q <= rra_pkg::CNT_W'(COUNT_CAP),
		"request counter beyond its cap")

endmodule

`default_nettype wire

@@ verif/tb_range_reservation_admission_core.sv @@
`timescale 1ns / 1ps

module tb_range_reservation_admission_core;

	localparam int NSLOT = rra_pkg::NUM_SLOTS_DEF;
	localparam int unsigned COUNT_CAP = (rra_pkg::MAX_REQUESTS_DEF < rra_pkg::CNT_MAX) ?
		rra_pkg::MAX_REQUESTS_DEF : rra_pkg::CNT_MAX;
	localparam logic [rra_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int AHEAD = 0;          // ledger used while building the stimulus
	localparam int LIVE  = 1;          // ledger advanced on each taken transaction
	localparam int RANDOM_ITEMS = 580;
	localparam longint CYCLE_LIMIT = 2_000_000;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [rra_pkg::FUNC_W-1:0] func;
		logic [rra_pkg::AMT_W-1:0]  amount;
		logic [rra_pkg::SLOT_W-1:0] lo;
		logic [rra_pkg::SLOT_W-1:0] hi;
		logic                       drain;
	} admit_cmd_t;

	typedef struct packed {
		logic                      failed;
		logic [rra_pkg::CNT_W-1:0] fail_idx;
		logic [rra_pkg::CNT_W-1:0] seen;
	} admit_status_t;

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [rra_pkg::FUNC_W-1:0] func = rra_pkg::FUNC_LOAD;
	logic [rra_pkg::AMT_W-1:0] amount = '0;
	logic [rra_pkg::SLOT_W-1:0] first_slot = '0;
	logic [rra_pkg::SLOT_W-1:0] last_slot = '0;
	logic busy;
	logic done;
	logic failed;
	logic [rra_pkg::CNT_W-1:0] first_failing_request;
	logic [rra_pkg::CNT_W-1:0] requests_seen;

	admit_cmd_t cmd_backlog[$];
	admit_status_t status_due[$];

	bit [rra_pkg::AMT_W-1:0] cap_copy [2][NSLOT];
	bit [rra_pkg::CNT_W-1:0] cnt_copy [2];
	bit fail_copy [2];
	bit [rra_pkg::CNT_W-1:0] idx_copy [2];
	bit slot_loaded [NSLOT];

	int n_err = 0;
	int n_checked = 0;
	int n_taken = 0;
	int n_fail_results = 0;
	int n_restarts = 0;
	int n_long_walks = 0;
	longint cycles = 0;
	int burst_left = 0;
	int gap_left = 0;

	range_reservation_admission_core u_top (
		.clk                   (clk),
		.arst_n                (arst_n),
		.start                 (start),
		.busy                  (busy),
		.func                  (func),
		.amount                (amount),
		.first_slot            (first_slot),
		.last_slot             (last_slot),
		.done                  (done),
		.failed                (failed),
		.first_failing_request (first_failing_request),
		.requests_seen         (requests_seen)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Advance one ledger by one transaction. Returns 1 if the slot walk would read
	// a slot never loaded; with dry set, nothing in the ledger changes.
	function automatic bit reserve_step(input int who, input admit_cmd_t c, input bit dry,
			output admit_status_t s);
		bit [rra_pkg::CNT_W-1:0] cnt;
		bit flag;
		bit [rra_pkg::CNT_W-1:0] idx;
		bit blank;
		bit walking;
		int unsigned i;
		int unsigned top;
		cnt = cnt_copy[who];
		flag = fail_copy[who];
		idx = idx_copy[who];
		blank = 1'b0;
		case (c.func)
			rra_pkg::FUNC_LOAD: begin
				if (!dry && c.lo < NSLOT)
					cap_copy[who][c.lo] = c.amount;
			end
			rra_pkg::FUNC_REQUEST: begin
				if (cnt < COUNT_CAP) begin
					cnt = cnt + 1'b1;
					if (!flag && c.lo <= c.hi && c.lo < NSLOT) begin
						top = (c.hi >= NSLOT) ? NSLOT - 1 : c.hi;
						i = c.lo;
						walking = 1'b1;
						while (walking && i <= top) begin
							if (!slot_loaded[i])
								blank = 1'b1;
							if (c.amount > cap_copy[who][i]) begin
								flag = 1'b1;
								idx = cnt;
								walking = 1'b0;
							end else if (!dry) begin
								cap_copy[who][i] = cap_copy[who][i] - c.amount;
							end
							i++;
						end
					end
				end
			end
			rra_pkg::FUNC_RESTART: begin
				cnt = '0;
				flag = 1'b0;
				idx = '0;
			end
			default: ;
		endcase
		if (!dry) begin
			cnt_copy[who] = cnt;
			fail_copy[who] = flag;
			idx_copy[who] = idx;
		end
		s = '{failed: flag, fail_idx: idx, seen: cnt};
		return blank;
	endfunction

	// Queue a transaction unless it would read an unloaded slot.
	function automatic bit put(input logic [rra_pkg::FUNC_W-1:0] f,
			input logic [rra_pkg::AMT_W-1:0] amt, input logic [rra_pkg::SLOT_W-1:0] lo,
			input logic [rra_pkg::SLOT_W-1:0] hi, input bit drain);
		admit_cmd_t c;
		admit_status_t s;
		c = '{func: f, amount: amt, lo: lo, hi: hi, drain: drain};
		if (reserve_step(AHEAD, c, 1'b1, s))
			return 1'b0;
		void'(reserve_step(AHEAD, c, 1'b0, s));
		if (f == rra_pkg::FUNC_LOAD)
			slot_loaded[lo] = 1'b1;
		if (f == rra_pkg::FUNC_REQUEST && hi >= lo && hi - lo >= 16)
			n_long_walks++;
		cmd_backlog.push_back(c);
		return 1'b1;
	endfunction

	// Driver: hold while busy, otherwise retire the taken transaction and launch the next.
	always @(posedge clk) begin
		admit_status_t st;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!(start && busy)) begin
			if (start) begin
				void'(reserve_step(LIVE, cmd_backlog[0], 1'b0, st));
				status_due.push_back(st);
				cmd_backlog.pop_front();
				n_taken++;
			end
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (cmd_backlog.size() > 0 &&
					!(cmd_backlog[0].drain && status_due.size() > 0)) begin
				start <= 1'b1;
				func <= cmd_backlog[0].func;
				amount <= cmd_backlog[0].amount;
				first_slot <= cmd_backlog[0].lo;
				last_slot <= cmd_backlog[0].hi;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 15);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every strobe retires the oldest expectation.
	always @(posedge clk) begin
		admit_status_t want;
		if (arst_n && done) begin
			if (status_due.size() == 0) begin
				n_err++;
				$display("%0t: unexpected result failed=%0b first_failing=%0d seen=%0d",
					$time, failed, first_failing_request, requests_seen);
			end else begin
				want = status_due.pop_front();
				n_checked++;
				if (want.failed)
					n_fail_results++;
				if (failed !== want.failed) begin
					n_err++;
					$display("%0t: failed expected %0b actual %0b", $time, want.failed, failed);
				end
				if (first_failing_request !== want.fail_idx) begin
					n_err++;
					$display("%0t: first_failing_request expected %0d actual %0d",
						$time, want.fail_idx, first_failing_request);
				end
				if (requests_seen !== want.seen) begin
					n_err++;
					$display("%0t: requests_seen expected %0d actual %0d",
						$time, want.seen, requests_seen);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d results outstanding", $time, status_due.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int n_rand;
		int unsigned k;
		int unsigned base;
		int unsigned lo;
		int unsigned hi;
		int unsigned run_end;
		int unsigned nreq;
		int unsigned pick;
		logic [rra_pkg::AMT_W-1:0] capv;
		logic [rra_pkg::AMT_W-1:0] minc;
		logic [rra_pkg::AMT_W-1:0] amt;

		// Directed: field extremes, exact fit, empty range, unused code, failure, restart
		void'(put(rra_pkg::FUNC_LOAD, 32'hFFFF_FFFF, 10'd0, 10'd1023, 1'b0));
		void'(put(rra_pkg::FUNC_LOAD, 32'd0, 10'd1023, 10'd0, 1'b0));
		void'(put(rra_pkg::FUNC_LOAD, 32'd5, 10'd1, 10'd0, 1'b0));
		void'(put(rra_pkg::FUNC_LOAD, 32'd5, 10'd2, 10'd0, 1'b0));
		void'(put(rra_pkg::FUNC_REQUEST, 32'd0, 10'd1023, 10'd1023, 1'b0));
		void'(put(rra_pkg::FUNC_REQUEST, 32'hFFFF_FFFF, 10'd0, 10'd0, 1'b0));
		void'(put(rra_pkg::FUNC_REQUEST, 32'd3, 10'd1, 10'd2, 1'b0));
		void'(put(rra_pkg::FUNC_REQUEST, 32'd0, 10'd2, 10'd1, 1'b0));
		void'(put(rra_pkg::FUNC_REQUEST, 32'hFFFF_FFFF, 10'd1023, 10'd0, 1'b0));
		void'(put(FUNC_UNUSED, 32'hA5A5_5A5A, 10'd1023, 10'd0, 1'b0));
		void'(put(rra_pkg::FUNC_REQUEST, 32'd3, 10'd1, 10'd2, 1'b0));
		void'(put(rra_pkg::FUNC_REQUEST, 32'd1, 10'd0, 10'd1023, 1'b0));
		void'(put(rra_pkg::FUNC_REQUEST, 32'd0, 10'd5, 10'd9, 1'b0));
		void'(put(rra_pkg::FUNC_RESTART, 32'hFFFF_FFFF, 10'd1023, 10'd1023, 1'b1));
		void'(put(rra_pkg::FUNC_REQUEST, 32'd2, 10'd1, 10'd2, 1'b0));
		void'(put(rra_pkg::FUNC_LOAD, 32'd7, 10'd1022, 10'd0, 1'b0));
		void'(put(rra_pkg::FUNC_REQUEST, 32'd8, 10'd1022, 10'd1023, 1'b0));
		void'(put(rra_pkg::FUNC_RESTART, 32'd0, 10'd0, 10'd0, 1'b0));
		void'(put(rra_pkg::FUNC_LOAD, 32'd1, 10'd1023, 10'd0, 1'b0));
		void'(put(rra_pkg::FUNC_REQUEST, 32'd1, 10'd1022, 10'd1023, 1'b0));
		void'(put(rra_pkg::FUNC_REQUEST, 32'd1, 10'd1023, 10'd1023, 1'b0));
		void'(put(rra_pkg::FUNC_RESTART, 32'd0, 10'd0, 10'd0, 1'b0));
		void'(put(rra_pkg::FUNC_RESTART, 32'd0, 10'd0, 10'd0, 1'b0));

		n_rand = 0;
		while (n_rand < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				// load a run of slots, then reserve against it
				k = ($urandom_range(0, 6) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 6);
				base = $urandom_range(0, NSLOT - k);
				run_end = base + k - 1;
				for (int unsigned j = 0; j < k; j++) begin
					case ($urandom_range(0, 3))
						0: capv = $urandom;
						1: capv = $urandom_range(0, 100);
						2: capv = 32'hFFFF_FFFF;
						default: capv = $urandom_range(1000, 1_000_000);
					endcase
					if (put(rra_pkg::FUNC_LOAD, capv, rra_pkg::SLOT_W'(base + j),
							rra_pkg::SLOT_W'($urandom_range(0, NSLOT - 1)), 1'b0))
						n_rand++;
				end
				nreq = $urandom_range(1, 4);
				for (int unsigned r = 0; r < nreq; r++) begin
					lo = base + $urandom_range(0, k - 1);
					hi = $urandom_range(lo, run_end);
					minc = 32'hFFFF_FFFF;
					for (int unsigned j = lo; j <= hi; j++)
						if (cap_copy[AHEAD][j] < minc)
							minc = cap_copy[AHEAD][j];
					// reach to the top slot; dropped if the walk would read a slot never loaded
					if (k >= 20 && $urandom_range(0, 2) == 0)
						hi = NSLOT - 1;
					case ($urandom_range(0, 5))
						0: amt = minc;
						1: amt = minc + 1'b1;
						2: amt = '0;
						3: amt = $urandom;
						4: amt = minc >> 1;
						default: amt = minc >> $urandom_range(0, 4);
					endcase
					if (put(rra_pkg::FUNC_REQUEST, amt, rra_pkg::SLOT_W'(lo),
							rra_pkg::SLOT_W'(hi), 1'b0))
						n_rand++;
				end
			end else if (pick < 70) begin
				if (put(rra_pkg::FUNC_RESTART, $urandom,
						rra_pkg::SLOT_W'($urandom_range(0, NSLOT - 1)),
						rra_pkg::SLOT_W'($urandom_range(0, NSLOT - 1)),
						$urandom_range(0, 2) == 0))
					n_rand++;
			end else if (pick < 75) begin
				void'(put(FUNC_UNUSED, $urandom, rra_pkg::SLOT_W'($urandom_range(0, NSLOT - 1)),
					rra_pkg::SLOT_W'($urandom_range(0, NSLOT - 1)), 1'b0));
			end else if (pick < 85) begin
				lo = $urandom_range(1, NSLOT - 1);
				hi = $urandom_range(0, lo - 1);
				if (put(rra_pkg::FUNC_REQUEST, $urandom, rra_pkg::SLOT_W'(lo),
						rra_pkg::SLOT_W'(hi), 1'b0))
					n_rand++;
			end else begin
				// noise: dropped if the walk would read a slot never loaded
				lo = $urandom_range(0, NSLOT - 1);
				hi = ($urandom_range(0, 1) == 0) ? $urandom_range(lo, NSLOT - 1)
					: ((lo + 4 < NSLOT) ? lo + $urandom_range(0, 4) : lo);
				if (put(rra_pkg::FUNC_REQUEST, $urandom, rra_pkg::SLOT_W'(lo),
						rra_pkg::SLOT_W'(hi), 1'b0))
					n_rand++;
			end
		end

		foreach (cmd_backlog[q])
			if (cmd_backlog[q].func == rra_pkg::FUNC_RESTART)
				n_restarts++;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() > 0 || status_due.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d transactions taken, %0d results checked, %0d mismatches",
			n_taken, n_checked, n_err);
		$display("covered %0d restarts, %0d results with a failed request, %0d long walks",
			n_restarts, n_fail_results, n_long_walks);
		if (n_err == 0 && status_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
